// ===== hw/rtl/hfc_pkg.sv =====
// ----------------------------------------------------------------------------
// hfc_pkg: shared types and constants
// Action codes and format constants for the half/float converter.
// ----------------------------------------------------------------------------
package hfc_pkg;

  localparam int unsigned ActionWidth  = 3;
  localparam int unsigned OperandWidth = 32;

  typedef enum logic [ActionWidth-1:0] {
    ACT_NEAREST  = 3'd0,
    ACT_CEIL     = 3'd1,
    ACT_FLOOR    = 3'd2,
    ACT_TRUNCATE = 3'd3,
    ACT_TO_FLOAT = 3'd4
  } action_t;

  localparam logic [7:0]  ExpTiny     = 8'h67;
  localparam logic [7:0]  ExpHuge     = 8'h8E;
  localparam logic [7:0]  ExpSubLimit = 8'h71;
  localparam logic [7:0]  ExpSubBase  = 8'h72;
  localparam logic [7:0]  ExpBias     = 8'h70;
  localparam logic [15:0] HalfInf     = 16'h7C00;
  localparam logic [31:0] FloatQnan   = 32'h7FC0_0000;
  localparam logic [31:0] FloatInf    = 32'h7F80_0000;

endpackage

// ===== hw/rtl/hfc_stream_if.sv =====
// ----------------------------------------------------------------------------
// hfc_stream_if: valid/ready channel
// Carries one beat of a parameterized payload width.
// ----------------------------------------------------------------------------
interface hfc_stream_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/half_float_converter_core.sv =====
// ----------------------------------------------------------------------------
// half_float_converter_core: binary32/binary16 converter
//
//   channel  direction  payload
//   in       sink       action[2:0], operand_bits[31:0]
//   out      source     result_bits[31:0]
//
// Input register, one level of conversion logic, result register.
// Sustains one beat per cycle while out is ready; each beat passes through the
// input register, then the result register. The input register refills
// whenever the result register frees up, so a stall on out holds both stages.
// rst clears the valid flags only.
module half_float_converter_core
  import hfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  hfc_stream_if.sink   in_ch,
  hfc_stream_if.source out_ch
);
  logic [2:0]  action;
  logic [31:0] operand;
  logic        stage_valid;
  logic [31:0] result_bits;
  logic        result_valid;
  logic [15:0] half;
  logic [31:0] widened;
  logic [31:0] result_next;
  logic        stage_ready;

  assign stage_ready  = !result_valid || out_ch.ready;
  assign in_ch.ready  = !stage_valid || stage_ready;
  assign out_ch.valid = result_valid;
  assign out_ch.data  = result_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        stage_valid <= in_ch.valid;
      end
      if (stage_ready) begin
        result_valid <= stage_valid;
      end
    end
    if (in_ch.ready && in_ch.valid) begin
      action  <= in_ch.data[34:32];
      operand <= in_ch.data[31:0];
    end
    if (stage_ready && stage_valid) begin
      result_bits <= result_next;
    end
  end

  hfc_to_half u_to_half (
    .action (action_t'(action)),
    .x      (operand),
    .half   (half)
  );

  hfc_to_float u_to_float (
    .h (operand[15:0]),
    .f (widened)
  );

  always_comb begin
    case (action)
      ACT_NEAREST, ACT_CEIL, ACT_FLOOR, ACT_TRUNCATE: result_next = {16'd0, half};
      ACT_TO_FLOAT: result_next = widened;
      default: result_next = 32'd0;
    endcase
  end
endmodule

// ===== hw/rtl/hfc_to_half.sv =====
// ----------------------------------------------------------------------------
// hfc_to_half: binary32 to binary16
// Rounding modes nearest (ties away), ceiling, floor and fast truncate.
// ----------------------------------------------------------------------------
module hfc_to_half
  import hfc_pkg::*;
(
  input  action_t     action,
  input  logic [31:0] x,
  output logic [15:0] half
);
  logic [15:0] s;
  logic [7:0]  e;
  logic [11:0] f11;
  logic [9:0]  f10;
  logic        left;
  logic        bump;
  logic [15:0] norm_base;
  logic [4:0]  sh_a;
  logic [4:0]  sh_b;
  logic [15:0] nearest;
  logic [15:0] directed;
  logic [10:0] dsub;
  logic [15:0] fast;
  logic        nan;

  always_comb begin
    s         = {x[31], 15'd0};
    e         = x[30:23];
    f11       = {1'b1, x[22:12]};
    f10       = x[22:13];
    left      = x[12:0] != 13'd0;
    bump      = left && (x[31] == (action == ACT_FLOOR));
    nan       = (e == 8'hFF) && (x[22:0] != 23'd0);
    // Subnormal shift is only used when e lies in 0x67..0x70.
    sh_a      = 5'(ExpSubBase - e);
    sh_b      = 5'(ExpSubLimit - e);
    norm_base = s | {1'b0, 5'(e - ExpBias), 10'd0};
    if (e < ExpSubLimit) begin
      nearest = s | 16'((f11 >> sh_a) + 12'((f11 >> sh_b) & 12'd1));
    end else begin
      nearest = (norm_base | {6'd0, f11[10:1]}) + {15'd0, f11[0]};
    end
    dsub = {1'b1, f10} >> sh_b;
    if (e < ExpSubLimit) begin
      directed = s | ({5'd0, dsub} + {15'd0, bump});
    end else begin
      directed = (norm_base | {6'd0, f10}) + {15'd0, bump};
    end
    fast = {x[31], x[30], x[26:23], x[22:13]};
    if (action == ACT_TRUNCATE) begin
      half = fast;
    end else if (e < ExpTiny) begin
      half = s;
    end else if (e > ExpHuge) begin
      half = s | HalfInf | {15'd0, nan};
    end else if (action == ACT_NEAREST) begin
      half = nearest;
    end else begin
      half = directed;
    end
  end
endmodule

// ===== hw/rtl/hfc_to_float.sv =====
// ----------------------------------------------------------------------------
// hfc_to_float: binary16 to binary32
// Exact widening, including normalization of subnormal halves.
// ----------------------------------------------------------------------------
module hfc_to_float
  import hfc_pkg::*;
(
  input  logic [15:0] h,
  output logic [31:0] f
);
  logic [31:0] s;
  logic [4:0]  e;
  logic [9:0]  m;
  logic [3:0]  p;
  logic [22:0] mfrac;

  always_comb begin
    s = {h[15], 31'd0};
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    // Priority search for the leading one of a ten-bit mantissa.
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        p = 4'(i);
      end
    end
    mfrac = 23'({13'd0, m} << (5'd23 - {1'b0, p}));
    if (e == 5'h1F) begin
      f = (m != 10'd0) ? FloatQnan : (s | FloatInf);
    end else if (e != 5'd0) begin
      f = s | {1'b0, 8'({3'd0, e} + 8'd112), m, 13'd0};
    end else if (m == 10'd0) begin
      f = s;
    end else begin
      f = s | {1'b0, 8'({4'd0, p} + 8'd103), mfrac};
    end
  end
endmodule

// ===== tb/half_float_converter_checker.sv =====
// ----------------------------------------------------------------------------
// half_float_converter_checker: conversion predictor and result compare
// Watches both channels of the converter. Each accepted input beat queues
// its predicted result. Each accepted output beat is compared with the
// oldest queued value.
// ----------------------------------------------------------------------------
module half_float_converter_checker
  import hfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [34:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_data,
  output int          fail_count,
  output int          pending_count
);

  logic [31:0] expected_results[$];

  function automatic logic [31:0] out_of_range_half(logic [31:0] x, output bit done);
    logic [31:0] s;
    logic [7:0]  e;
    s = {16'd0, x[31], 15'd0};
    e = x[30:23];
    done = 1'b1;
    if (e < ExpTiny) return s;
    if (e > ExpHuge) return s | {16'd0, HalfInf} | ((e == 8'hFF && x[22:0] != 0) ? 1 : 0);
    done = 1'b0;
    return 32'd0;
  endfunction

  function automatic logic [31:0] half_nearest(logic [31:0] x);
    logic [31:0] s, f, r, e;
    bit done;
    s = {16'd0, x[31], 15'd0};
    e = {24'd0, x[30:23]};
    f = {21'd0, x[22:12]};
    r = out_of_range_half(x, done);
    if (done) return r;
    if (e < ExpSubLimit) begin
      f = f | 32'h800;
      return s | ((f >> (ExpSubBase - e)) + ((f >> (ExpSubLimit - e)) & 1));
    end
    r = s | ((e - ExpBias) << 10) | (f >> 1);
    return (r + (f & 1)) & 32'hFFFF;
  endfunction

  // Directed modes bump by one whenever any of the low 13 bits is set and the sign
  // points away from zero, even for subnormal results where more bits are shifted out.
  function automatic logic [31:0] half_directed(logic [31:0] x, bit toward_minus);
    logic [31:0] s, f, r, e;
    bit done, bump;
    s = {16'd0, x[31], 15'd0};
    e = {24'd0, x[30:23]};
    f = {22'd0, x[22:13]};
    bump = (x[12:0] != 0) && (x[31] == toward_minus);
    r = out_of_range_half(x, done);
    if (done) return r;
    if (e < ExpSubLimit) begin
      f = (f | 32'h400) >> (ExpSubLimit - e);
      if (bump) f = f + 1;
      return s | f;
    end
    r = s | ((e - ExpBias) << 10) | f;
    if (bump) r = r + 1;
    return r & 32'hFFFF;
  endfunction

  function automatic logic [31:0] widen_half(logic [31:0] x);
    logic [31:0] s, e, m;
    int p;
    s = {x[15], 31'd0};
    e = {27'd0, x[14:10]};
    m = {22'd0, x[9:0]};
    if (e == 31) return (m != 0) ? FloatQnan : (s | FloatInf);
    if (e != 0) return s | ((e + 112) << 23) | (m << 13);
    if (m == 0) return s;
    p = 9;
    while (m[p] == 1'b0) p--;
    return s | ((p + 103) << 23) | ((m << (23 - p)) & 32'h007F_FFFF);
  endfunction

  function automatic logic [31:0] convert(logic [2:0] act, logic [31:0] x);
    case (act)
      ACT_NEAREST:  return half_nearest(x);
      ACT_CEIL:     return half_directed(x, 1'b0);
      ACT_FLOOR:    return half_directed(x, 1'b1);
      ACT_TRUNCATE: return {16'd0, x[31], x[30], x[26:23], x[22:13]};
      ACT_TO_FLOAT: return widen_half(x);
      default:      return 32'd0;
    endcase
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(convert(in_data[34:32], in_data[31:0]));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          if (out_data !== expected_results[0]) begin
            if (fail_count < 10)
              $display("result_bits mismatch: expected %h actual %h",
                       expected_results[0], out_data);
            fail_count <= fail_count + 1;
          end
          void'(expected_results.pop_front());
        end
      end
    end
  end

endmodule

// ===== tb/half_float_converter_core_tb.sv =====
// ----------------------------------------------------------------------------
// half_float_converter_core_tb: converter testbench top
// Drives directed and random conversion beats with random gaps on the
// input and random stalls on the output, and reports the checker verdict.
// ----------------------------------------------------------------------------
module half_float_converter_core_tb;
  import hfc_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  bit   stimulus_done;

  hfc_stream_if #(.Width(35)) in_ch ();
  hfc_stream_if #(.Width(32)) out_ch ();

  half_float_converter_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  half_float_converter_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Exponents cluster around the half range so the rounding paths get most
  // of the beats; the rest are fully random patterns and special encodings.
  function automatic logic [31:0] random_operand(logic [2:0] act);
    logic [31:0] x;
    int roll;
    x = $urandom();
    roll = $urandom_range(0, 99);
    if (act == ACT_TO_FLOAT) begin
      if (roll < 10) x[14:10] = 5'h1F;
      else if (roll < 25) x[14:10] = 5'h00;
      else if (roll < 30) x[9:0] = 10'd0;
    end else if (roll < 60) begin
      x[30:23] = 8'($urandom_range(8'h64, 8'h91));
      if ($urandom_range(0, 3) == 0) x[12:0] = ($urandom_range(0, 1) != 0) ? 13'h1000 : 13'h0;
    end else if (roll < 68) begin
      x[30:23] = 8'hFF;
      if ($urandom_range(0, 1) != 0) x[22:0] = 23'd0;
    end else if (roll < 74) begin
      x[30:0] = ($urandom_range(0, 1) != 0) ? 31'h477F_E000 : 31'h477F_F000;
    end
    return x;
  endfunction

  task automatic send_beat(logic [2:0] act, logic [31:0] x);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= {act, x};
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Output stalls come in stretches: free flow, light stalls, heavy stalls.
  initial begin
    int stretch;
    int mode;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      stretch = $urandom_range(5, 60);
      mode = $urandom_range(0, 2);
      repeat (stretch) begin
        @(posedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  initial begin
    logic [2:0]  act;
    logic [31:0] directed_ops[$];
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    stimulus_done = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zeros, tiny, huge, NaN, subnormal edge, rounding carries into inf.
    directed_ops = '{32'h0000_0000, 32'h8000_0000, 32'h3380_0000, 32'hB300_0001,
                     32'h477F_F000, 32'h477F_E001, 32'hC77F_E001, 32'h7F80_0000,
                     32'hFFC0_0001, 32'h387F_F000, 32'h3BFF_F001, 32'hFFFF_FFFF};
    for (int a = ACT_NEAREST; a <= ACT_TRUNCATE; a++)
      foreach (directed_ops[i])
        if (i < 5 || a != ACT_TRUNCATE) send_beat(3'(a), directed_ops[i]);
    send_beat(ACT_TO_FLOAT, 32'hFFFF_7C01);
    send_beat(ACT_TO_FLOAT, 32'h0000_FC00);
    send_beat(ACT_TO_FLOAT, 32'h1234_8000);
    send_beat(ACT_TO_FLOAT, 32'h0000_0001);
    send_beat(ACT_TO_FLOAT, 32'h0000_03FF);
    send_beat(3'd5, 32'hFFFF_FFFF);
    send_beat(3'd7, 32'h3C00_0000);
    drain_results();

    for (int n = 0; n < 550; n++) begin
      if ($urandom_range(0, 19) == 0) act = 3'($urandom_range(5, 7));
      else act = 3'($urandom_range(ACT_NEAREST, ACT_TO_FLOAT));
      send_beat(act, random_operand(act));
      if (n == 275) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
